FILE: sv/bcbs_pkg.sv
// Package for the button click blink selector: field widths, register
// indexes, phase and click codes, reset values and the slot step function.
// No dependencies.
`timescale 1ns / 1ps

package bcbs_pkg;

  localparam int unsigned DEB_W      = 10;
  localparam int unsigned WIN_W      = 12;
  localparam int unsigned IVL_W      = 16;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned REPS_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_W      = 3;

  localparam int unsigned INTERVAL_COUNT_DEF = 4;
  localparam int unsigned INTERVAL_MAX       = 4;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DCLICK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL0 = 3'd2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 10'd40;
  localparam logic [WIN_W-1:0] DCLICK_RST   = 12'd350;
  localparam logic [IVL_W-1:0] INTERVAL_RST [INTERVAL_MAX] = '{
    16'd100, 16'd500, 16'd1000, 16'd2000
  };

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DEB1  = 3'd1,
    PH_HOLD1 = 3'd2,
    PH_REL1  = 3'd3,
    PH_WIN   = 3'd4,
    PH_DEB2  = 3'd5,
    PH_HOLD2 = 3'd6
  } click_phase_e;

  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_SINGLE = 2'd1,
    EVT_DOUBLE = 2'd2
  } click_evt_e;

  typedef struct packed {
    logic tick;
    logic level;
  } click_in_t;

  typedef struct packed {
    click_evt_e evt;
  } click_out_t;

  // One slot move: forward for a single click, back for a double, wrapping.
  function automatic logic [SLOT_W-1:0] step_slot(
    input logic [SLOT_W-1:0] slot,
    input logic              back,
    input logic [CNT_W-1:0]  count
  );
    logic [CNT_W-1:0] nxt;
    nxt = {1'b0, slot} + 3'd1;
    if (back) begin
      step_slot = (slot == '0) ? SLOT_W'(count - 3'd1) : slot - 2'd1;
    end else begin
      step_slot = (nxt >= count) ? '0 : nxt[SLOT_W-1:0];
    end
  endfunction

endpackage

FILE: sv/bcbs_if.sv
// Handshake channels of the button click blink selector: input items,
// result items and register writes. Uses bcbs_pkg for widths.
`timescale 1ns / 1ps

interface bcbs_in_if;
  import bcbs_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic              button_level;
  logic              press_kind;
  logic [REPS_W-1:0] repeat_count;
  modport source (output valid, action, button_level, press_kind, repeat_count,
                  input ready);
  modport sink   (input valid, action, button_level, press_kind, repeat_count,
                  output ready);
endinterface

interface bcbs_out_if;
  import bcbs_pkg::*;
  logic              valid;
  logic              ready;
  logic              cursor_visible;
  logic [IVL_W-1:0]  interval_ticks;
  logic [SLOT_W-1:0] interval_slot;
  logic [1:0]        click_event;
  modport source (output valid, cursor_visible, interval_ticks, interval_slot,
                  click_event, input ready);
  modport sink   (input valid, cursor_visible, interval_ticks, interval_slot,
                  click_event, output ready);
endinterface

interface bcbs_cfg_if;
  import bcbs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/bcbs_click.sv
// Debounced single/double click detector, advanced once per tick item.
// Depends on bcbs_pkg.
`timescale 1ns / 1ps

module bcbs_click import bcbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  click_in_t        ctl_i,
  input  logic [DEB_W-1:0] debounce_ticks_i,
  input  logic [WIN_W-1:0] dclick_ticks_i,
  output click_out_t       click_o
);

  click_phase_e     phase_q, phase_d;
  logic             lvl_prev_q, lvl_prev_d;
  logic [DEB_W-1:0] cnt_q, cnt_d;
  logic [WIN_W-1:0] win_q, win_d;

  logic             deb_done;
  logic [DEB_W-1:0] cnt_step;
  logic [WIN_W-1:0] win_sat;
  logic             win_over;
  logic             win_over_sat;
  logic             fall;
  click_evt_e       evt;

  assign deb_done     = ({1'b0, cnt_q} + 11'd1) >= {1'b0, debounce_ticks_i};
  assign cnt_step     = deb_done ? '0 : cnt_q + 10'd1;
  assign win_sat      = (win_q == '1) ? win_q : win_q + 12'd1;
  assign win_over     = win_q >= dclick_ticks_i;
  // second debounce judges the window after this tick has been counted
  assign win_over_sat = win_sat >= dclick_ticks_i;
  assign fall         = lvl_prev_q && !ctl_i.level;

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE:  if (fall) phase_d = PH_DEB1;
      PH_DEB1:  if (deb_done) phase_d = ctl_i.level ? PH_IDLE : PH_HOLD1;
      PH_HOLD1: if (ctl_i.level) phase_d = PH_REL1;
      PH_REL1:  if (deb_done) phase_d = PH_WIN;
      PH_WIN: begin
        if (win_over) phase_d = PH_IDLE;
        else if (!ctl_i.level) phase_d = PH_DEB2;
      end
      PH_DEB2: begin
        if (deb_done) begin
          if (!ctl_i.level) phase_d = PH_HOLD2;
          else if (win_over_sat) phase_d = PH_IDLE;
          else phase_d = PH_WIN;
        end
      end
      PH_HOLD2: if (ctl_i.level) phase_d = PH_IDLE;
      default:  phase_d = PH_IDLE;
    endcase
  end

  // click decision and counters
  always_comb begin
    evt   = EVT_NONE;
    cnt_d = cnt_q;
    win_d = win_q;
    case (phase_q)
      PH_IDLE:  if (fall) cnt_d = '0;
      PH_DEB1:  cnt_d = cnt_step;
      PH_HOLD1: if (ctl_i.level) cnt_d = '0;
      PH_REL1: begin
        cnt_d = cnt_step;
        if (deb_done) win_d = '0;
      end
      PH_WIN: begin
        win_d = win_sat;
        if (win_over) evt = EVT_SINGLE;
        else if (!ctl_i.level) cnt_d = '0;
      end
      PH_DEB2: begin
        win_d = win_sat;
        cnt_d = cnt_step;
        if (deb_done && ctl_i.level && win_over_sat) evt = EVT_SINGLE;
      end
      PH_HOLD2: if (ctl_i.level) evt = EVT_DOUBLE;
      default: ;
    endcase
    if (evt != EVT_NONE) begin
      cnt_d = '0;
      win_d = '0;
    end
  end

  assign lvl_prev_d  = ctl_i.level;
  assign click_o.evt = ctl_i.tick ? evt : EVT_NONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      lvl_prev_q <= 1'b1;
      cnt_q      <= '0;
      win_q      <= '0;
    end else if (ctl_i.tick) begin
      phase_q    <= phase_d;
      lvl_prev_q <= lvl_prev_d;
      cnt_q      <= cnt_d;
      win_q      <= win_d;
    end
  end

endmodule

FILE: sv/button_click_blink_selector.sv
// Top level of the button click blink selector: input stage, slot select,
// blink timer, register file and result stage. Depends on bcbs_pkg, bcbs_if
// and bcbs_click.
`timescale 1ns / 1ps

// One item is taken every clock cycle while the input stage is not stalled. An
// accepted item sits in the input register, the click detector, slot select
// and blink timer update from it in a single pass, and its result is held in
// the result register, which loads once the result stage is free, so each
// result passes the input register and then the result register.
// While a result waits to be taken the input stage stalls
// only once it is itself full. Register writes are taken every cycle and
// should be made while no item is in flight.
module button_click_blink_selector import bcbs_pkg::*; #(
  parameter int unsigned IntervalCount = INTERVAL_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bcbs_cfg_if.sink          cfg_i,
  bcbs_in_if.sink           in_i,
  bcbs_out_if.source        res_o
);

  localparam logic [CNT_W-1:0] Count = CNT_W'(IntervalCount);

  // registers
  logic [DEB_W-1:0] deb_ticks_q;
  logic [WIN_W-1:0] dclick_ticks_q;
  logic [IVL_W-1:0] ivl_q [IntervalCount];

  // input stage
  logic              s1_vld_q;
  logic              s1_action_q;
  logic              s1_level_q;
  logic              s1_kind_q;
  logic [REPS_W-1:0] s1_reps_q;
  logic              advance;

  // block state
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [IVL_W-1:0]  blink_q, blink_d;
  logic              vis_q, vis_d;

  // result stage
  logic              res_vld_q, res_vld_d;
  logic              res_vis_q;
  logic [IVL_W-1:0]  res_ivl_q;
  logic [SLOT_W-1:0] res_slot_q;
  click_evt_e        res_evt_q;

  click_in_t         click_in;
  click_out_t        click_out;
  logic [IVL_W-1:0]  ivl_cur;
  logic [IVL_W-1:0]  ivl_new;
  logic [IVL_W-1:0]  blink_inc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q    <= DEBOUNCE_RST;
      dclick_ticks_q <= DCLICK_RST;
      for (int i = 0; i < IntervalCount; i++) ivl_q[i] <= INTERVAL_RST[i];
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_DEBOUNCE) deb_ticks_q <= cfg_i.data[DEB_W-1:0];
      if (cfg_i.index == REG_DCLICK) dclick_ticks_q <= cfg_i.data[WIN_W-1:0];
      for (int i = 0; i < IntervalCount; i++) begin
        if (cfg_i.index == CFG_IDX_W'(REG_INTERVAL0 + CFG_IDX_W'(i))) begin
          ivl_q[i] <= cfg_i.data[IVL_W-1:0];
        end
      end
    end
  end

  // handshake: the input stage moves on whenever the result stage is free
  assign advance    = s1_vld_q && (!res_vld_q || res_o.ready);
  assign in_i.ready = !s1_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_action_q <= in_i.action;
      s1_level_q  <= in_i.button_level;
      s1_kind_q   <= in_i.press_kind;
      s1_reps_q   <= in_i.repeat_count;
    end
  end

  assign click_in.tick  = advance && !s1_action_q;
  assign click_in.level = s1_level_q;

  bcbs_click u_click (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (click_in),
    .debounce_ticks_i(deb_ticks_q),
    .dclick_ticks_i  (dclick_ticks_q),
    .click_o         (click_out)
  );

  always_comb begin
    ivl_cur = ivl_q[0];
    ivl_new = ivl_q[0];
    for (int i = 0; i < IntervalCount; i++) begin
      if (slot_q == SLOT_W'(i)) ivl_cur = ivl_q[i];
      if (slot_d == SLOT_W'(i)) ivl_new = ivl_q[i];
    end
  end

  assign blink_inc = blink_q + 16'd1;

  always_comb begin
    slot_d  = slot_q;
    blink_d = blink_q;
    vis_d   = vis_q;
    if (s1_action_q) begin
      // injected press, applied repeat_count times at once
      for (int k = 0; k < 3; k++) begin
        if (REPS_W'(k) < s1_reps_q) slot_d = step_slot(slot_d, s1_kind_q, Count);
      end
      if (s1_reps_q != '0) blink_d = '0;
    end else if (click_out.evt != EVT_NONE) begin
      slot_d  = step_slot(slot_q, click_out.evt == EVT_DOUBLE, Count);
      blink_d = '0;
    end else if (blink_inc >= ivl_cur) begin
      vis_d   = !vis_q;
      blink_d = '0;
    end else begin
      blink_d = blink_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      blink_q <= '0;
      vis_q   <= 1'b0;
    end else if (advance) begin
      slot_q  <= slot_d;
      blink_q <= blink_d;
      vis_q   <= vis_d;
    end
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (advance) res_vld_d = 1'b1;
    else if (res_o.ready) res_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_vis_q  <= vis_d;
      res_ivl_q  <= ivl_new;
      res_slot_q <= slot_d;
      res_evt_q  <= click_out.evt;
    end
  end

  assign res_o.valid          = res_vld_q;
  assign res_o.cursor_visible = res_vis_q;
  assign res_o.interval_ticks = res_ivl_q;
  assign res_o.interval_slot  = res_slot_q;
  assign res_o.click_event    = res_evt_q;

endmodule

FILE: dv/tb.sv
// Self-checking bench for button_click_blink_selector: directed and random
// click traffic, injected presses and register settings, checked per item.
// Depends on bcbs_pkg and the channel interfaces in bcbs_if.
`timescale 1ns / 1ps

module tb;
  import bcbs_pkg::*;

  localparam logic             ACT_TICK     = 1'b0;
  localparam logic             ACT_INJECT   = 1'b1;
  localparam logic             LVL_PRESSED  = 1'b0;
  localparam logic             LVL_RELEASED = 1'b1;
  localparam logic             KIND_SINGLE  = 1'b0;
  localparam logic             KIND_DOUBLE  = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE0 =
    CFG_IDX_W'(REG_INTERVAL0 + INTERVAL_COUNT_DEF);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = REG_SPARE0 + 3'd1;
  localparam int    SETTLE_CYCLES = 4;
  localparam int    CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic              drain;   // hold this item back until all results are in
    logic              action;
    logic              level;
    logic              kind;
    logic [REPS_W-1:0] reps;
  } press_item_t;

  typedef struct packed {
    logic              vis;
    logic [IVL_W-1:0]  ticks;
    logic [SLOT_W-1:0] slot;
    click_evt_e        evt;
  } cursor_res_t;

  logic clk_i;
  logic rst_ni;

  bcbs_cfg_if cfg_if ();
  bcbs_in_if  in_if ();
  bcbs_out_if res_if ();

  button_click_blink_selector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  // predictor state and register copy
  logic [DEB_W-1:0]  deb_cfg;
  logic [WIN_W-1:0]  win_cfg;
  logic [IVL_W-1:0]  ivl_cfg [INTERVAL_COUNT_DEF];
  logic              lvl_prev;
  click_phase_e      click_ph;
  logic [DEB_W-1:0]  deb_cnt;
  logic [WIN_W-1:0]  win_cnt;
  logic [SLOT_W-1:0] slot_sel;
  logic [IVL_W-1:0]  blink_cnt;
  logic              vis_flag;

  press_item_t sample_q [$];
  cursor_res_t cursor_due [$];
  press_item_t cur_item;

  int gen_cnt;
  int send_gap, take_gap;
  int send_gap_pct, take_gap_pct;
  int err_cnt, items_taken, results_seen, singles_seen, doubles_seen, reg_writes;
  int cycle_cnt;

  always #1 clk_i = ~clk_i;

  function automatic void model_reset();
    deb_cfg    = DEBOUNCE_RST;
    win_cfg    = DCLICK_RST;
    for (int k = 0; k < INTERVAL_COUNT_DEF; k++) ivl_cfg[k] = INTERVAL_RST[k];
    lvl_prev   = LVL_RELEASED;
    click_ph   = PH_IDLE;
    deb_cnt    = '0;
    win_cnt    = '0;
    slot_sel   = '0;
    blink_cnt  = '0;
    vis_flag   = 1'b0;
  endfunction

  function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DEBOUNCE: deb_cfg = val[DEB_W-1:0];
      REG_DCLICK:   win_cfg = val[WIN_W-1:0];
      default: begin
        if (idx >= REG_INTERVAL0 && idx < REG_SPARE0) begin
          ivl_cfg[SLOT_W'(idx - REG_INTERVAL0)] = val;
        end
      end
    endcase
  endfunction

  function automatic void shift_slot(input logic back);
    if (back) begin
      slot_sel = (slot_sel == '0) ? SLOT_W'(INTERVAL_COUNT_DEF - 1) : slot_sel - 1'b1;
    end else begin
      slot_sel = (int'(slot_sel) + 1 >= INTERVAL_COUNT_DEF) ? '0 : slot_sel + 1'b1;
    end
    blink_cnt = '0;
  endfunction

  // one debounce tick; true once the level is to be judged
  function automatic logic debounce_over();
    if (int'(deb_cnt) + 1 >= int'(deb_cfg)) begin
      deb_cnt = '0;
      return 1'b1;
    end
    deb_cnt = deb_cnt + 1'b1;
    return 1'b0;
  endfunction

  function automatic void win_step();
    if (win_cnt != '1) win_cnt = win_cnt + 1'b1;
  endfunction

  function automatic cursor_res_t predict_cursor(input press_item_t it);
    click_evt_e  evt;
    cursor_res_t r;
    int          k;
    evt = EVT_NONE;
    if (it.action == ACT_INJECT) begin
      for (k = 0; k < int'(it.reps); k++) shift_slot(it.kind == KIND_DOUBLE);
    end else begin
      case (click_ph)
        PH_IDLE: begin
          if (lvl_prev == LVL_RELEASED && it.level == LVL_PRESSED) begin
            click_ph = PH_DEB1;
            deb_cnt  = '0;
          end
        end
        PH_DEB1: begin
          if (debounce_over()) click_ph = (it.level == LVL_PRESSED) ? PH_HOLD1 : PH_IDLE;
        end
        PH_HOLD1: begin
          if (it.level == LVL_RELEASED) begin
            click_ph = PH_REL1;
            deb_cnt  = '0;
          end
        end
        PH_REL1: begin
          if (debounce_over()) begin
            click_ph = PH_WIN;
            win_cnt  = '0;
          end
        end
        PH_WIN: begin
          // window judged before the sample
          if (win_cnt >= win_cfg) begin
            evt = EVT_SINGLE;
          end else if (it.level == LVL_PRESSED) begin
            click_ph = PH_DEB2;
            deb_cnt  = '0;
          end
          win_step();
        end
        PH_DEB2: begin
          win_step();
          if (debounce_over()) begin
            if (it.level == LVL_PRESSED) click_ph = PH_HOLD2;
            else if (win_cnt >= win_cfg) evt = EVT_SINGLE;
            else click_ph = PH_WIN;
          end
        end
        PH_HOLD2: begin
          if (it.level == LVL_RELEASED) evt = EVT_DOUBLE;
        end
        default: click_ph = PH_IDLE;
      endcase
      lvl_prev = it.level;
      if (evt != EVT_NONE) begin
        click_ph = PH_IDLE;
        deb_cnt  = '0;
        win_cnt  = '0;
        shift_slot(evt == EVT_DOUBLE);
      end else begin
        blink_cnt = blink_cnt + 1'b1;
        if (blink_cnt >= ivl_cfg[slot_sel]) begin
          vis_flag  = ~vis_flag;
          blink_cnt = '0;
        end
      end
    end
    r.vis   = vis_flag;
    r.ticks = ivl_cfg[slot_sel];
    r.slot  = slot_sel;
    r.evt   = evt;
    return r;
  endfunction

  // stimulus builders
  function automatic void push_tick(input logic level);
    press_item_t it;
    it.drain  = 1'b0;
    it.action = ACT_TICK;
    it.level  = level;
    it.kind   = 1'($urandom);
    it.reps   = REPS_W'($urandom);
    sample_q.push_back(it);
    gen_cnt++;
  endfunction

  function automatic void push_inject(input logic kind, input logic [REPS_W-1:0] reps);
    press_item_t it;
    it.drain  = 1'b0;
    it.action = ACT_INJECT;
    it.level  = 1'($urandom);
    it.kind   = kind;
    it.reps   = reps;
    sample_q.push_back(it);
    gen_cnt++;
  endfunction

  function automatic void push_run(input logic level, input int len);
    for (int k = 0; k < len; k++) push_tick(level);
  endfunction

  function automatic int deb_eff();
    return (deb_cfg == '0) ? 1 : int'(deb_cfg);
  endfunction

  // clean press/release with random slack, optionally a second press in the window
  function automatic void gen_click(input logic dbl);
    int deb, win;
    deb = deb_eff();
    win = int'(win_cfg);
    push_run(LVL_RELEASED, $urandom_range(1, 2));
    push_run(LVL_PRESSED, 1 + deb + $urandom_range(0, 2));
    if ($urandom_range(0, 5) == 0) push_inject(1'($urandom), REPS_W'($urandom));
    push_run(LVL_RELEASED, 1 + deb);
    if (dbl && win > 0) begin
      push_run(LVL_RELEASED, $urandom_range(0, win - 1));
      push_run(LVL_PRESSED, 1 + deb + $urandom_range(0, 2));
      push_run(LVL_RELEASED, 1);
    end else begin
      push_run(LVL_RELEASED, win + 1 + $urandom_range(0, 2));
    end
  endfunction

  function automatic void gen_bounce();
    int top, runs;
    top  = (deb_eff() + 1 > 8) ? 8 : deb_eff() + 1;
    runs = $urandom_range(2, 6);
    for (int k = 0; k < runs; k++) push_run(1'($urandom), $urandom_range(1, top));
  endfunction

  function automatic void fill_random(input int count);
    int          mode, i;
    press_item_t tmp;
    gen_cnt = 0;
    while (gen_cnt < count) begin
      mode = $urandom_range(0, 9);
      // long debounce: keep to short traffic
      if (deb_eff() > 50 && mode < 6) mode = $urandom_range(6, 9);
      case (mode)
        6, 7:    gen_bounce();
        8:       for (int k = $urandom_range(1, 6); k > 0; k--) push_tick(1'($urandom));
        9:       push_inject(1'($urandom), REPS_W'($urandom));
        default: gen_click($urandom_range(0, 1) == 1);
      endcase
    end
    i = $urandom_range(0, sample_q.size() - 1);
    tmp = sample_q[i];
    tmp.drain = 1'b1;
    sample_q[i] = tmp;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    load_reg(idx, val);
    reg_writes++;
  endtask

  task automatic set_all(input logic [DEB_W-1:0] deb, input logic [WIN_W-1:0] win,
                         input logic [IVL_W-1:0] i0, input logic [IVL_W-1:0] i1,
                         input logic [IVL_W-1:0] i2, input logic [IVL_W-1:0] i3);
    write_reg(REG_DEBOUNCE, {6'($urandom), deb});
    write_reg(REG_DCLICK, {4'($urandom), win});
    write_reg(REG_INTERVAL0, i0);
    write_reg(REG_INTERVAL0 + 3'd1, i1);
    write_reg(REG_INTERVAL0 + 3'd2, i2);
    write_reg(REG_INTERVAL0 + 3'd3, i3);
  endtask

  function automatic logic [IVL_W-1:0] rand_ivl();
    return ($urandom_range(0, 3) == 0) ? IVL_W'($urandom) : IVL_W'($urandom_range(0, 12));
  endfunction

  task automatic random_setting();
    set_all(DEB_W'($urandom_range(0, 6)), WIN_W'($urandom_range(0, 24)),
            rand_ivl(), rand_ivl(), rand_ivl(), rand_ivl());
  endtask

  function automatic void pick_idling();
    int pick;
    pick = $urandom_range(0, 2);
    send_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
    pick = $urandom_range(0, 2);
    take_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
  endfunction

  // wait until every queued item is sent and every result is back
  task automatic settle();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || cursor_due.size() != 0 || in_if.valid);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // item driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        cursor_due.push_back(predict_cursor(cur_item));
        items_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (sample_q.size() != 0 &&
                     !(sample_q[0].drain && cursor_due.size() != 0)) begin
          cur_item = sample_q.pop_front();
          in_if.valid        <= 1'b1;
          in_if.action       <= cur_item.action;
          in_if.button_level <= cur_item.level;
          in_if.press_kind   <= cur_item.kind;
          in_if.repeat_count <= cur_item.reps;
          if ($urandom_range(0, 99) < send_gap_pct) send_gap = $urandom_range(1, 4);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : mon
    cursor_res_t due;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (cursor_due.size() == 0) begin
          $display("%0t: result with nothing expected (vis %0d ticks %0d slot %0d evt %0d)",
                   $time, res_if.cursor_visible, res_if.interval_ticks,
                   res_if.interval_slot, res_if.click_event);
          err_cnt++;
        end else begin
          due = cursor_due.pop_front();
          if (due.evt == EVT_SINGLE) singles_seen++;
          if (due.evt == EVT_DOUBLE) doubles_seen++;
          if (res_if.cursor_visible !== due.vis) begin
            $display("%0t: cursor_visible expected %0d got %0d",
                     $time, due.vis, res_if.cursor_visible);
            err_cnt++;
          end
          if (res_if.interval_ticks !== due.ticks) begin
            $display("%0t: interval_ticks expected %0d got %0d",
                     $time, due.ticks, res_if.interval_ticks);
            err_cnt++;
          end
          if (res_if.interval_slot !== due.slot) begin
            $display("%0t: interval_slot expected %0d got %0d",
                     $time, due.slot, res_if.interval_slot);
            err_cnt++;
          end
          if (res_if.click_event !== due.evt) begin
            $display("%0t: click_event expected %0d got %0d",
                     $time, due.evt, res_if.click_event);
            err_cnt++;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < take_gap_pct) take_gap = $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cycle_cnt = 0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.action = ACT_TICK;
    in_if.button_level = LVL_RELEASED;
    in_if.press_kind = KIND_SINGLE;
    in_if.repeat_count = '0;
    res_if.ready = 1'b0;
    send_gap = 0;
    take_gap = 0;
    send_gap_pct = 15;
    take_gap_pct = 15;
    err_cnt = 0;
    items_taken = 0;
    results_seen = 0;
    singles_seen = 0;
    doubles_seen = 0;
    reg_writes = 0;
    model_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: walk the slots with injected presses
    push_inject(KIND_SINGLE, 2'd0);
    push_inject(KIND_SINGLE, 2'd1);
    push_inject(KIND_SINGLE, 2'd3);
    push_inject(KIND_DOUBLE, 2'd2);
    push_inject(KIND_DOUBLE, 2'd1);
    push_inject(KIND_SINGLE, 2'd2);
    push_run(LVL_RELEASED, 1);
    push_run(LVL_PRESSED, 1);
    push_run(LVL_RELEASED, 1);
    settle();

    // debounce and window of one, zero and full-scale intervals, spare indexes ignored
    set_all(DEB_W'(1), WIN_W'(1), 16'd0, 16'd1, 16'hFFFF, 16'd3);
    write_reg(REG_SPARE0, 16'hFFFF);
    write_reg(REG_SPARE1, 16'hFFFF);
    push_run(LVL_RELEASED, 1);                 // pending press fails debounce
    push_run(LVL_PRESSED, 2);                  // single click
    push_run(LVL_RELEASED, 4);
    push_run(LVL_PRESSED, 2);                  // double click
    push_run(LVL_RELEASED, 2);
    push_run(LVL_PRESSED, 2);
    push_run(LVL_RELEASED, 1);
    push_run(LVL_PRESSED, 2);                  // second press bounces after window
    push_run(LVL_RELEASED, 2);
    push_run(LVL_PRESSED, 1);
    push_run(LVL_RELEASED, 1);
    push_inject(KIND_DOUBLE, 2'd3);
    settle();

    // zero debounce and zero window
    set_all('0, '0, 16'd0, 16'd0, 16'd1, 16'd2);
    pick_idling();
    fill_random(60);
    settle();

    for (int p = 0; p < 5; p++) begin
      random_setting();
      pick_idling();
      fill_random(80);
      settle();
    end

    // largest settings: short traffic only
    set_all('1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    pick_idling();
    fill_random(40);
    settle();

    // closing stretch at full rate
    random_setting();
    send_gap_pct = 0;
    take_gap_pct = 0;
    fill_random(60);
    settle();

    $display("summary: %0d items taken, %0d results checked, %0d register writes",
             items_taken, results_seen, reg_writes);
    $display("summary: %0d single and %0d double clicks decided, %0d mismatches",
             singles_seen, doubles_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
